@@ sv/plt_pkg.sv @@
// ----------------------------------------------------------------------------
// plt_pkg: shared types and constants of the positional list table
// Entry layout, request codes, widths and the RAM access bundle.
// ----------------------------------------------------------------------------
package plt_pkg;

  // list size and widths
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 8;
  localparam int POS_W    = 8;
  localparam int KEY_W    = 32;
  localparam int PL_W     = 64;

  // request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PL_W-1:0]         payload;
  } entry_t;

  // read and write request of the sequencer to the RAM
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
  } mem_req_t;

endpackage

@@ sv/plt_req_if.sv @@
// ----------------------------------------------------------------------------
// plt_req_if: request channel
// Valid/ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface plt_req_if;
  import plt_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [POS_W-1:0]        position;
  logic signed [KEY_W-1:0] key;
  logic [PL_W-1:0]         payload;

  modport source (output valid, mode, position, key, payload, input ready);
  modport sink   (input valid, mode, position, key, payload, output ready);
endinterface

@@ sv/plt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// plt_rsp_if: result channel
// Valid/ready handshake carrying one operation result.
// ----------------------------------------------------------------------------
interface plt_rsp_if;
  import plt_pkg::*;

  logic             valid;
  logic             ready;
  logic             ok;
  logic [POS_W-1:0] found_position;
  logic [CNT_W-1:0] count;
  logic             empty_res;
  logic             full_res;

  modport source (output valid, ok, found_position, count, empty_res, full_res,
                  input ready);
  modport sink   (input valid, ok, found_position, count, empty_res, full_res,
                  output ready);
endinterface

@@ sv/plt_ram.sv @@
// ----------------------------------------------------------------------------
// plt_ram: entry store
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module plt_ram (
  input  logic              clk,
  input  plt_pkg::mem_req_t mem_req,
  output plt_pkg::entry_t   rd_data
);
  import plt_pkg::*;

  entry_t mem [CAPACITY];
  entry_t rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/plt_ctrl.sv @@
// ----------------------------------------------------------------------------
// plt_ctrl: list sequencer
// Takes a request, walks the store one entry a cycle (shift up, shift down
// or key compare) and stages the result in the output register.
// ----------------------------------------------------------------------------
module plt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  plt_req_if.sink         in_req,
  plt_rsp_if.source       out_rsp,
  output plt_pkg::mem_req_t mem_req,
  input  plt_pkg::entry_t rd_data
);
  import plt_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // control state
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // request and walk payload
  logic [1:0]              mode_r, mode_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic [PL_W-1:0]         pl_r, pl_nxt;
  logic [ADDR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [ADDR_W-1:0]       pend_addr_r, pend_addr_nxt;
  logic                    ok_r, ok_nxt;
  logic [POS_W-1:0]        found_r, found_nxt;

  // output register
  logic             o_ok_r, o_ok_nxt;
  logic [POS_W-1:0] o_found_r, o_found_nxt;
  logic [CNT_W-1:0] o_count_r, o_count_nxt;

  logic accept;
  logic slot_free;

  assign accept    = in_req.valid && in_req.ready;
  assign slot_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    pend_nxt      = 1'b0;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    pl_nxt        = pl_r;
    rd_ptr_nxt    = rd_ptr_r;
    pend_addr_nxt = pend_addr_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    o_ok_nxt      = o_ok_r;
    o_found_nxt   = o_found_r;
    o_count_nxt   = o_count_r;
    mem_req       = '0;

    case (state_r)
      // decode request and set up the walk
      ST_IDLE: begin
        if (accept) begin
          mode_nxt  = in_req.mode;
          pos_nxt   = in_req.position;
          key_nxt   = in_req.key;
          pl_nxt    = in_req.payload;
          ok_nxt    = 1'b0;
          found_nxt = '0;
          state_nxt = ST_FIN;
          case (in_req.mode)
            MODE_INSERT: begin
              if (count_r != CNT_W'(CAPACITY) && in_req.position != '0 &&
                  {1'b0, in_req.position} <= ({1'b0, count_r} + 9'd1)) begin
                left_nxt   = CNT_W'(count_r - CNT_W'(in_req.position) + 1'b1);
                rd_ptr_nxt = ADDR_W'(count_r - 1'b1);
                state_nxt  = ST_WALK;
              end
            end
            MODE_SEARCH: begin
              left_nxt   = count_r;
              rd_ptr_nxt = '0;
              state_nxt  = ST_WALK;
            end
            MODE_REMOVE: begin
              if (in_req.position != '0 && CNT_W'(in_req.position) <= count_r) begin
                left_nxt   = CNT_W'(count_r - CNT_W'(in_req.position));
                rd_ptr_nxt = ADDR_W'(in_req.position);
                state_nxt  = ST_WALK;
              end
            end
            default: begin
              count_nxt = '0;
              ok_nxt    = 1'b1;
            end
          endcase
        end
      end

      // one read issued and one read result consumed per cycle
      ST_WALK: begin
        if (left_r != '0) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_ptr_r;
          left_nxt      = left_r - 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = rd_ptr_r;
          rd_ptr_nxt    = (mode_r == MODE_INSERT) ? rd_ptr_r - 1'b1 : rd_ptr_r + 1'b1;
        end

        if (pend_r) begin
          // writes land clear of the read stream, so no forwarding needed
          case (mode_r)
            MODE_INSERT: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = pend_addr_r + 1'b1;
              mem_req.wdata = rd_data;
            end
            MODE_REMOVE: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = pend_addr_r - 1'b1;
              mem_req.wdata = rd_data;
            end
            MODE_SEARCH: begin
              if (rd_data.key == key_r) begin
                ok_nxt    = 1'b1;
                found_nxt = POS_W'({1'b0, pend_addr_r}) + 1'b1;
                pend_nxt  = 1'b0;
                left_nxt  = '0;
                state_nxt = ST_FIN;
              end
            end
            default: ;
          endcase
        end else if (left_r == '0) begin
          // walk finished
          state_nxt = ST_FIN;
          case (mode_r)
            MODE_INSERT: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = ADDR_W'(pos_r - 1'b1);
              mem_req.wdata = '{key: key_r, payload: pl_r};
              count_nxt     = count_r + 1'b1;
              ok_nxt        = 1'b1;
            end
            MODE_REMOVE: begin
              count_nxt = count_r - 1'b1;
              ok_nxt    = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // hand the result to the output register
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_ok_nxt      = ok_r;
          o_found_nxt   = found_r;
          o_count_nxt   = count_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    pos_r       <= pos_nxt;
    key_r       <= key_nxt;
    pl_r        <= pl_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    pend_addr_r <= pend_addr_nxt;
    ok_r        <= ok_nxt;
    found_r     <= found_nxt;
    o_ok_r      <= o_ok_nxt;
    o_found_r   <= o_found_nxt;
    o_count_r   <= o_count_nxt;
  end

  // channel outputs
  assign in_req.ready           = (state_r == ST_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.ok             = o_ok_r;
  assign out_rsp.found_position = o_found_r;
  assign out_rsp.count          = o_count_r;
  assign out_rsp.empty_res      = (o_count_r == '0);
  assign out_rsp.full_res       = (o_count_r == CNT_W'(CAPACITY));

endmodule

@@ sv/positional_list_table.sv @@
// ----------------------------------------------------------------------------
// positional_list_table: positional list of keyed entries
// Insert, search, remove and clear on a list held in a single-port-pair RAM.
//
//   channel   dir  fields
//   in_req    in   mode, position, key, payload
//   out_rsp   out  ok, found_position, count, empty_res, full_res
//
// Clear and refused requests go straight to the result stage; insert and
// remove walk the entries that move, search walks until a hit or the end
// of the list, one entry a cycle. The next request is taken in the same
// cycle as the result appears. Reset clears the state and the count; the
// RAM needs no clearing pass. A new request is taken while a result waits;
// a stalled result holds the final step.
// ----------------------------------------------------------------------------
module positional_list_table (
  input  logic      clk,
  input  logic      rst_n,
  plt_req_if.sink   in_req,
  plt_rsp_if.source out_rsp
);
  import plt_pkg::*;

  mem_req_t mem_req;
  entry_t   rd_data;

  plt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  plt_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  // count never passes the capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> (out_rsp.count <= CNT_W'(CAPACITY)))
    else $error("count above capacity");

  // a reported position implies a hit
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.found_position != '0) |-> out_rsp.ok)
    else $error("found position without ok");

  // a taken request drops ready in the following cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> !in_req.ready)
    else $error("request taken while busy");

  // RAM never reads and writes the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.re && mem_req.we) |-> (mem_req.raddr != mem_req.waddr))
    else $error("RAM read and write on the same entry");
`endif

endmodule
